// ===== hw/rtl/warn_step_frequency_throttle_defines.svh =====
// Assertion macros shared by the throttle RTL.
`ifndef WARN_STEP_FREQUENCY_THROTTLE_DEFINES_SVH
`define WARN_STEP_FREQUENCY_THROTTLE_DEFINES_SVH

// Checks that cons holds whenever ante holds in the same cycle.
`define WSFT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("throttle assertion failed");

// Checks that cons holds in the cycle after ante.
`define WSFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("throttle assertion failed");

`endif

// ===== hw/rtl/wsft_pkg.sv =====
// Types and constants for the warning-step frequency throttle.
package wsft_pkg;

	localparam int MAX_LEVELS_DEF = 16;
	localparam int FREQ_BITS_DEF  = 24;
	localparam int COUNT_BITS_DEF = 8;

	localparam int         LVL_BITS  = 4;
	localparam logic [3:0] TOP_RESET = 4'd15;

	typedef enum logic [1:0] {
		REQ_LOAD,
		REQ_WARN,
		REQ_UNTHROTTLE,
		REQ_POLICY
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HALF,
		ST_SCAN,
		ST_LEVEL,
		ST_CAP,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/warn_step_frequency_throttle.sv =====
// Warning-step frequency throttle: table memory, level walk and policy clamp.
//
// Usage: items enter on in_valid/in_ready and each item gives exactly one result on
// out_valid/out_ready. Load items write one entry of the descending frequency table,
// warning items raise the saturating count and step the cap level, unthrottle items
// return to level 0, and policy items are answered with the smaller of the request
// and the cap. The top level register is written on cfg_valid/cfg_ready, always ready.
// Load and policy items go straight to the result; an unthrottle first updates the cap
// when the level moves. A warning walks the table through the single read port of the
// table memory, one entry a cycle. One item is in work at a time; the next is taken in
// the cycle after the current result enters the output register, so a result may wait
// there while the next item runs.
// A stalled receiver holds the result; a finished item then waits for the slot.
// Reset clears level, cap, count and handshake state and sets the top level to 15.
// The table memory is not cleared: an entry must be loaded before it is used.
module warn_step_frequency_throttle #(
	parameter int MAX_LEVELS = wsft_pkg::MAX_LEVELS_DEF,
	parameter int FREQ_BITS  = wsft_pkg::FREQ_BITS_DEF,
	parameter int COUNT_BITS = wsft_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            req_type,
	input  logic [3:0]            entry_index,
	input  logic [FREQ_BITS-1:0]  freq_khz,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [3:0]            cap_level,
	output logic [FREQ_BITS-1:0]  cap_khz,
	output logic [COUNT_BITS-1:0] warn_count,
	output logic                  cap_changed,
	output logic [FREQ_BITS-1:0]  granted_khz
);

`include "warn_step_frequency_throttle_defines.svh"

	localparam int         AW      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int         SW      = ((COUNT_BITS > 5) ? COUNT_BITS : 5) + 1;
	localparam logic [3:0] TOP_LIM = (MAX_LEVELS > 16) ? 4'd15 : 4'(MAX_LEVELS - 1);

	wsft_pkg::state_t state_q, state_next;

	logic [FREQ_BITS-1:0]  mem [MAX_LEVELS];
	logic [FREQ_BITS-1:0]  mem_rdata_q;
	logic                  mem_rd_en;
	logic [AW-1:0]         mem_rd_addr;
	logic                  mem_wr_en;

	logic [3:0]            top_q;
	logic [3:0]            level_q;
	logic [FREQ_BITS-1:0]  cap_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;

	logic [3:0]            i_q;
	logic [4:0]            cand_q;
	logic [3:0]            target_q;
	logic [FREQ_BITS-1:0]  half_q;
	logic                  changed_q;
	logic [FREQ_BITS-1:0]  granted_q;

	logic [3:0]            out_level_q;
	logic [FREQ_BITS-1:0]  out_cap_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  out_changed_q;
	logic [FREQ_BITS-1:0]  out_granted_q;

	logic                  in_fire;
	logic                  warn_fire;
	logic                  out_free;
	logic [3:0]            eff_top;
	logic                  scan_hit;
	logic                  scan_end;
	logic [SW-1:0]         lvl_sum;
	logic [3:0]            new_level;
	logic                  entry_ok;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign warn_fire = in_fire && (wsft_pkg::req_t'(req_type) == wsft_pkg::REQ_WARN);
	assign out_free  = !out_valid_q || out_ready;
	assign eff_top   = (top_q > TOP_LIM) ? TOP_LIM : top_q;
	assign scan_hit  = half_q >= mem_rdata_q;
	assign scan_end  = scan_hit || (i_q == eff_top);
	assign lvl_sum   = SW'(cand_q) + SW'(count_q);
	assign new_level = (lvl_sum > SW'(eff_top)) ? eff_top : lvl_sum[3:0];
	assign entry_ok  = 32'(entry_index) < 32'(MAX_LEVELS);

	always_comb begin
		state_next = state_q;
		case (state_q)
			wsft_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (wsft_pkg::req_t'(req_type))
						wsft_pkg::REQ_WARN: state_next = wsft_pkg::ST_HALF;
						wsft_pkg::REQ_UNTHROTTLE: begin
							if (count_q != '0 && level_q != 4'd0) begin
								state_next = wsft_pkg::ST_CAP;
							end else begin
								state_next = wsft_pkg::ST_DONE;
							end
						end
						default: state_next = wsft_pkg::ST_DONE;
					endcase
				end
			end
			wsft_pkg::ST_HALF: begin
				state_next = (eff_top == 4'd0) ? wsft_pkg::ST_LEVEL : wsft_pkg::ST_SCAN;
			end
			wsft_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_next = wsft_pkg::ST_LEVEL;
				end
			end
			wsft_pkg::ST_LEVEL: begin
				state_next = (new_level != level_q) ? wsft_pkg::ST_CAP : wsft_pkg::ST_DONE;
			end
			wsft_pkg::ST_CAP: state_next = wsft_pkg::ST_DONE;
			wsft_pkg::ST_DONE: begin
				if (out_free) begin
					state_next = wsft_pkg::ST_IDLE;
				end
			end
			default: state_next = wsft_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		case (state_q)
			wsft_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					case (wsft_pkg::req_t'(req_type))
						wsft_pkg::REQ_LOAD: mem_wr_en = entry_ok;
						wsft_pkg::REQ_WARN: mem_rd_en = 1'b1;
						wsft_pkg::REQ_UNTHROTTLE: mem_rd_en = 1'b1;
						default: mem_rd_en = 1'b0;
					endcase
				end
			end
			wsft_pkg::ST_HALF: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = AW'(1);
			end
			wsft_pkg::ST_SCAN: begin
				mem_rd_en   = !scan_end;
				mem_rd_addr = AW'(i_q + 4'd1);
			end
			wsft_pkg::ST_LEVEL: begin
				mem_rd_en   = new_level != level_q;
				mem_rd_addr = AW'(new_level);
			end
			default: mem_rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			mem[AW'(entry_index)] <= freq_khz;
		end
		if (mem_rd_en) begin
			mem_rdata_q <= mem[mem_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wsft_pkg::ST_IDLE;
			top_q       <= wsft_pkg::TOP_RESET;
			level_q     <= '0;
			cap_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready) begin
				top_q <= cfg_data;
			end
			if (in_fire) begin
				case (wsft_pkg::req_t'(req_type))
					wsft_pkg::REQ_LOAD: begin
						if (entry_index == 4'd0) begin
							cap_q <= freq_khz;
						end
					end
					wsft_pkg::REQ_WARN: begin
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
					end
					wsft_pkg::REQ_UNTHROTTLE: count_q <= '0;
					default: count_q <= count_q;
				endcase
			end
			if (state_q == wsft_pkg::ST_CAP) begin
				level_q <= target_q;
				cap_q   <= mem_rdata_q;
			end
			if (state_q == wsft_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			changed_q <= 1'b0;
			target_q  <= 4'd0;
			granted_q <= '0;
			if (wsft_pkg::req_t'(req_type) == wsft_pkg::REQ_POLICY) begin
				granted_q <= (freq_khz < cap_q) ? freq_khz : cap_q;
			end
		end
		case (state_q)
			wsft_pkg::ST_HALF: begin
				half_q <= mem_rdata_q >> 1;
				i_q    <= 4'd1;
				cand_q <= 5'd1;
			end
			wsft_pkg::ST_SCAN: begin
				if (scan_hit) begin
					cand_q <= {1'b0, i_q};
				end else begin
					cand_q <= {1'b0, i_q} + 5'd1;
					i_q    <= i_q + 4'd1;
				end
			end
			wsft_pkg::ST_LEVEL: target_q <= new_level;
			wsft_pkg::ST_CAP: changed_q <= 1'b1;
			wsft_pkg::ST_DONE: begin
				if (out_free) begin
					out_level_q   <= level_q;
					out_cap_q     <= cap_q;
					out_count_q   <= count_q;
					out_changed_q <= changed_q;
					out_granted_q <= granted_q;
				end
			end
			default: half_q <= half_q;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign cap_level   = out_level_q;
	assign cap_khz     = out_cap_q;
	assign warn_count  = out_count_q;
	assign cap_changed = out_changed_q;
	assign granted_khz = out_granted_q;

	`WSFT_ASSERT_SAME(a_cap_after_read, state_q == wsft_pkg::ST_CAP, $past(mem_rd_en))
	`WSFT_ASSERT_SAME(a_port_exclusive, mem_wr_en, !mem_rd_en)
	`WSFT_ASSERT_NEXT(a_warn_counts, warn_fire && count_q != '1, count_q == $past(count_q) + 1'b1)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the warning-step throttle: directed and random traffic.
module testbench;

	localparam int LIMIT_CYCLES = 500000;

	typedef struct packed {
		logic [3:0]  level;
		logic [23:0] cap;
		logic [7:0]  count;
		logic        changed;
		logic [23:0] granted;
	} cap_report_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [3:0]  entry_index;
	logic [23:0] freq_khz;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  cap_level;
	logic [23:0] cap_khz;
	logic [7:0]  warn_count;
	logic        cap_changed;
	logic [23:0] granted_khz;

	logic [23:0] level_freqs [16];
	logic [3:0]  level_now;
	logic [23:0] cap_now;
	logic [7:0]  warn_now;
	logic [3:0]  top_now;

	cap_report_t cap_reports_q[$];
	int          err_count = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;

	warn_step_frequency_throttle u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.entry_index (entry_index),
		.freq_khz    (freq_khz),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cap_level   (cap_level),
		.cap_khz     (cap_khz),
		.warn_count  (warn_count),
		.cap_changed (cap_changed),
		.granted_khz (granted_khz)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 26);
	end

	function automatic cap_report_t throttle_step(input wsft_pkg::req_t req,
			input logic [3:0] idx, input logic [23:0] freq);
		cap_report_t rep;
		logic [23:0] half;
		int          i;
		int          target;
		bit          do_move;
		rep = '0;
		do_move = 1'b0;
		target = 0;
		case (req)
			wsft_pkg::REQ_LOAD: begin
				level_freqs[idx] = freq;
				if (idx == 4'd0)
					cap_now = freq;
			end
			wsft_pkg::REQ_WARN: begin
				if (warn_now != 8'hFF)
					warn_now = warn_now + 8'd1;
				half = level_freqs[0] >> 1;
				i = 1;
				while (i <= int'(top_now) && half < level_freqs[i])
					i++;
				target = i + int'(warn_now);
				if (target > int'(top_now))
					target = int'(top_now);
				do_move = 1'b1;
			end
			wsft_pkg::REQ_UNTHROTTLE: begin
				if (warn_now != 8'd0) begin
					warn_now = 8'd0;
					do_move = 1'b1;
				end
			end
			wsft_pkg::REQ_POLICY: begin
				rep.granted = (freq < cap_now) ? freq : cap_now;
			end
			default: ;
		endcase
		if (do_move && target != int'(level_now)) begin
			level_now = 4'(target);
			cap_now = level_freqs[target];
			rep.changed = 1'b1;
		end
		rep.level = level_now;
		rep.cap = cap_now;
		rep.count = warn_now;
		return rep;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : check_cap_reports
		cap_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (cap_reports_q.size() == 0) begin
				$display("%0t: result with no item waiting, level %0d cap %0h count %0d",
					$time, cap_level, cap_khz, warn_count);
				err_count++;
			end else begin
				want = cap_reports_q.pop_front();
				compare_field("cap_level", 32'(want.level), 32'(cap_level));
				compare_field("cap_khz", 32'(want.cap), 32'(cap_khz));
				compare_field("warn_count", 32'(want.count), 32'(warn_count));
				compare_field("cap_changed", 32'(want.changed), 32'(cap_changed));
				compare_field("granted_khz", 32'(want.granted), 32'(granted_khz));
			end
		end
	end

	task automatic send_item(input wsft_pkg::req_t req, input logic [3:0] idx,
			input logic [23:0] freq);
		int gap;
		gap = (!calm && $urandom_range(99) < 26) ? int'($urandom_range(20, 1)) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		entry_index <= idx;
		freq_khz <= freq;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cap_reports_q.push_back(throttle_step(req, idx, freq));
	endtask

	task automatic drain_results;
		@(negedge clk);
		in_valid <= 1'b0;
		while (cap_reports_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_top_level(input logic [3:0] value);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		top_now = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_descending_table;
		logic [23:0] freq;
		freq = ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom);
		for (int k = 0; k < 16; k++) begin
			send_item(wsft_pkg::REQ_LOAD, 4'(k), freq);
			freq = freq - 24'($urandom % (32'(freq) / 3 + 1));
		end
	endtask

	task automatic send_random_item;
		int          pick;
		logic [3:0]  idx;
		logic [23:0] freq;
		pick = $urandom_range(99);
		idx = 4'($urandom);
		freq = 24'($urandom);
		if (pick < 10) begin
			send_item(wsft_pkg::REQ_LOAD, idx, freq);
		end else if (pick < 50) begin
			send_item(wsft_pkg::REQ_WARN, idx, freq);
		end else if (pick < 62) begin
			send_item(wsft_pkg::REQ_UNTHROTTLE, idx, freq);
		end else begin
			if ($urandom_range(1) == 1)
				freq = cap_now + 24'($urandom_range(8)) - 24'd4;
			send_item(wsft_pkg::REQ_POLICY, idx, freq);
		end
	endtask

	task automatic test_reset_state;
		send_item(wsft_pkg::REQ_POLICY, 4'd15, 24'hFFFFFF);
		send_item(wsft_pkg::REQ_LOAD, 4'd0, 24'hFFFFFF);
		send_item(wsft_pkg::REQ_POLICY, 4'd0, 24'h000000);
		send_item(wsft_pkg::REQ_POLICY, 4'd0, 24'h123456);
		send_item(wsft_pkg::REQ_UNTHROTTLE, 4'd0, 24'h000000);
	endtask

	task automatic test_table_load;
		for (int k = 1; k < 16; k++)
			send_item(wsft_pkg::REQ_LOAD, 4'(k), 24'hFFFFFF - 24'(k << 20));
	endtask

	task automatic test_warning_steps;
		send_item(wsft_pkg::REQ_WARN, 4'd15, 24'hFFFFFF);
		send_item(wsft_pkg::REQ_WARN, 4'd0, 24'h000000);
		send_item(wsft_pkg::REQ_POLICY, 4'd0, 24'hFFFFFF);
		send_item(wsft_pkg::REQ_UNTHROTTLE, 4'd15, 24'hFFFFFF);
		send_item(wsft_pkg::REQ_WARN, 4'd5, 24'h0AAAAA);
		send_item(wsft_pkg::REQ_UNTHROTTLE, 4'd0, 24'h000000);
	endtask

	task automatic test_no_half_level;
		send_item(wsft_pkg::REQ_LOAD, 4'd0, 24'h000000);
		send_item(wsft_pkg::REQ_WARN, 4'd0, 24'h000000);
		send_item(wsft_pkg::REQ_WARN, 4'd0, 24'h000000);
		send_item(wsft_pkg::REQ_POLICY, 4'd0, 24'hFFFFFF);
		send_item(wsft_pkg::REQ_UNTHROTTLE, 4'd0, 24'h000000);
		send_item(wsft_pkg::REQ_LOAD, 4'd0, 24'hFFFFFF);
	endtask

	task automatic test_top_level_changes;
		write_top_level(4'd15);
		send_item(wsft_pkg::REQ_WARN, 4'd0, 24'h000000);
		send_item(wsft_pkg::REQ_WARN, 4'd0, 24'h000000);
		write_top_level(4'd3);
		send_item(wsft_pkg::REQ_POLICY, 4'd0, 24'hFFFFFF);
		send_item(wsft_pkg::REQ_WARN, 4'd0, 24'h000000);
		write_top_level(4'd0);
		send_item(wsft_pkg::REQ_WARN, 4'd0, 24'h000000);
		send_item(wsft_pkg::REQ_UNTHROTTLE, 4'd0, 24'h000000);
		write_top_level(4'd15);
	endtask

	task automatic test_count_saturation;
		calm = 1'b1;
		for (int n = 0; n < 300; n++) begin
			if (n % 64 == 63)
				send_item(wsft_pkg::REQ_POLICY, 4'($urandom), 24'($urandom));
			else
				send_item(wsft_pkg::REQ_WARN, 4'($urandom), 24'($urandom));
		end
		send_item(wsft_pkg::REQ_UNTHROTTLE, 4'd0, 24'h000000);
		calm = 1'b0;
	endtask

	task automatic test_random_traffic;
		logic [3:0] top_setting;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: top_setting = 4'd15;
				1: top_setting = 4'd0;
				3: top_setting = 4'd7;
				default: top_setting = 4'($urandom);
			endcase
			write_top_level(top_setting);
			calm = (phase == 3);
			if (phase != 1)
				load_descending_table();
			for (int n = 0; n < 200; n++) begin
				if (phase == 2 && n == 100)
					drain_results();
				send_random_item();
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 4'd0;
		in_valid = 1'b0;
		req_type = 2'd0;
		entry_index = 4'd0;
		freq_khz = 24'd0;
		out_ready = 1'b0;
		level_now = 4'd0;
		cap_now = 24'd0;
		warn_now = 8'd0;
		top_now = wsft_pkg::TOP_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_table_load();
		test_warning_steps();
		test_no_half_level();
		test_top_level_changes();
		test_count_saturation();
		test_random_traffic();

		drain_results();
		repeat (25) @(posedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
